// ===== hdl/mta_pkg.sv =====
// ---------------------------------------------------------------------------
// mta_pkg
// Shared types and constants for the matrix transform accumulator.
// ---------------------------------------------------------------------------
package mta_pkg;

	localparam int DIM_DEF       = 4;
	localparam int FRAC_BITS_DEF = 16;
	localparam int STRIDE        = 4;
	localparam int CELLS         = 16;

	typedef enum logic [3:0] {
		OP_WR_CUR  = 4'd0,
		OP_WR_OPD  = 4'd1,
		OP_RD_CUR  = 4'd2,
		OP_POSTMUL = 4'd3,
		OP_PREMUL  = 4'd4,
		OP_ADD     = 4'd5,
		OP_SUB     = 4'd6,
		OP_SCALE   = 4'd7,
		OP_XFORM   = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_COPY,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;    // capture the input beat
		logic       clr_acc; // start a new dot product
		logic       mac;     // multiply-accumulate one step
		logic       store;   // finish one element or component
		logic       copy;    // copy temp into current (one row)
		logic [1:0] i;
		logic [1:0] j;
		logic [1:0] k;
		logic       finish;  // latch the result
	} cmd_t;

	typedef struct packed {
		logic [3:0] op;
	} sts_t;

endpackage

// ===== hdl/mta_datapath.sv =====
// ---------------------------------------------------------------------------
// mta_datapath
// Matrix stores, one shared multiply-accumulate unit and the result register.
// ---------------------------------------------------------------------------
module mta_datapath #(
	parameter int DIM       = mta_pkg::DIM_DEF,
	parameter int FRAC_BITS = mta_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mta_pkg::cmd_t      cmd,
	output mta_pkg::sts_t      sts,
	input  logic [3:0]         op,
	input  logic [1:0]         row,
	input  logic [1:0]         col,
	input  logic signed [31:0] value,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [31:0] vec_w,
	output logic signed [31:0] res_0,
	output logic signed [31:0] res_1,
	output logic signed [31:0] res_2,
	output logic signed [31:0] res_3,
	output logic               saturated
);
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
	// room for four full-range truncated products
	localparam int AW = 66 - FRAC_BITS;

	logic signed [31:0] cur_q [mta_pkg::CELLS];
	logic signed [31:0] opd_q [mta_pkg::CELLS];
	logic signed [31:0] tmp_q [mta_pkg::CELLS];
	logic signed [31:0] vec_q [4];
	logic signed [31:0] res_q [4];
	logic [3:0]         op_q;
	logic [1:0]         row_q, col_q;
	logic signed [31:0] val_q;
	logic signed [AW-1:0] acc_q;
	logic               flag_q;
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [AW-1:0] term, sum;
	logic signed [31:0] sat_v;
	logic               sat_f;
	logic [3:0]         ij, ik, kj;
	logic               in_range;

	assign ij = {cmd.i, cmd.j};
	assign ik = {cmd.i, cmd.k};
	assign kj = {cmd.k, cmd.j};
	assign in_range = (32'(row_q) < DIM) && (32'(col_q) < DIM);
	assign sts.op = op_q;

	always_comb begin
		case (op_q)
			mta_pkg::OP_POSTMUL: begin ma = cur_q[ik]; mb = opd_q[kj]; end
			mta_pkg::OP_PREMUL:  begin ma = opd_q[ik]; mb = cur_q[kj]; end
			mta_pkg::OP_SCALE:   begin ma = cur_q[ij]; mb = val_q;     end
			mta_pkg::OP_XFORM:   begin ma = cur_q[ik]; mb = vec_q[cmd.k]; end
			default:             begin ma = cur_q[ij]; mb = opd_q[ij]; end
		endcase
		prod = 64'(ma) * 64'(mb);
		term = AW'(prod >>> FRAC_BITS);
		if (op_q == mta_pkg::OP_ADD)
			term = AW'(cur_q[ij]) + AW'(opd_q[ij]);
		else if (op_q == mta_pkg::OP_SUB)
			term = AW'(cur_q[ij]) - AW'(opd_q[ij]);
		sum = acc_q + term;
		sat_f = 1'b1;
		if (sum > AW'(32'sh7fffffff)) sat_v = 32'sh7fffffff;
		else if (sum < -AW'(33'sh080000000)) sat_v = 32'sh80000000;
		else begin sat_v = sum[31:0]; sat_f = 1'b0; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < mta_pkg::CELLS; n++) begin
				cur_q[n] <= ((n / mta_pkg::STRIDE == n % mta_pkg::STRIDE)
					&& (n / mta_pkg::STRIDE < DIM)) ? ONE : '0;
				opd_q[n] <= '0;
			end
		end else begin
			if (cmd.finish && in_range) begin
				if (op_q == mta_pkg::OP_WR_CUR) cur_q[{row_q, col_q}] <= val_q;
				if (op_q == mta_pkg::OP_WR_OPD) opd_q[{row_q, col_q}] <= val_q;
			end
			if (cmd.store && op_q != mta_pkg::OP_XFORM
				&& op_q != mta_pkg::OP_POSTMUL && op_q != mta_pkg::OP_PREMUL)
				cur_q[ij] <= sat_v;
			if (cmd.copy)
				for (int n = 0; n < mta_pkg::STRIDE; n++)
					cur_q[{cmd.i, 2'(n)}] <= tmp_q[{cmd.i, 2'(n)}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op; row_q <= row; col_q <= col; val_q <= value;
			vec_q[0] <= vec_x; vec_q[1] <= vec_y; vec_q[2] <= vec_z; vec_q[3] <= vec_w;
			flag_q <= 1'b0;
			acc_q <= '0;
			for (int n = 0; n < 4; n++) res_q[n] <= '0;
			for (int n = 0; n < mta_pkg::CELLS; n++) tmp_q[n] <= '0;
		end else begin
			if (cmd.store) acc_q <= '0;
			else if (cmd.mac) acc_q <= cmd.clr_acc ? term : sum;
			if (cmd.store) begin
				flag_q <= flag_q | sat_f;
				tmp_q[ij] <= sat_v;
				if (op_q == mta_pkg::OP_XFORM) res_q[cmd.i] <= sat_v;
			end
			if (cmd.finish && op_q == mta_pkg::OP_RD_CUR && in_range)
				res_q[0] <= cur_q[{row_q, col_q}];
		end
	end

	// result register, loaded once per item
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_0 <= (op_q == mta_pkg::OP_RD_CUR && in_range) ? cur_q[{row_q, col_q}]
				: res_q[0];
			res_1 <= res_q[1];
			res_2 <= res_q[2];
			res_3 <= res_q[3];
			saturated <= flag_q;
		end
	end
endmodule

// ===== hdl/mta_ctrl.sv =====
// ---------------------------------------------------------------------------
// mta_ctrl
// Sequencer stepping the shared MAC over i, j, k for the arithmetic operations.
// ---------------------------------------------------------------------------
module mta_ctrl #(
	parameter int DIM = mta_pkg::DIM_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output mta_pkg::cmd_t cmd,
	input  mta_pkg::sts_t sts
);
	localparam logic [1:0] LAST = 2'(DIM - 1);

	mta_pkg::state_t state_q, state_d;
	logic [1:0] i_q, j_q, k_q;
	logic       ov_q;
	logic       is_dot, is_ew, is_mm, last_k, last_ij;

	assign is_mm  = sts.op == mta_pkg::OP_POSTMUL || sts.op == mta_pkg::OP_PREMUL;
	assign is_dot = is_mm || sts.op == mta_pkg::OP_XFORM;
	assign is_ew  = sts.op == mta_pkg::OP_ADD || sts.op == mta_pkg::OP_SUB
		|| sts.op == mta_pkg::OP_SCALE;
	assign last_k  = !is_dot || k_q == LAST;
	assign last_ij = i_q == LAST && (j_q == LAST || sts.op == mta_pkg::OP_XFORM);

	assign in_ready  = state_q == mta_pkg::ST_IDLE && (!ov_q || out_ready);
	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mta_pkg::ST_IDLE: if (in_valid && in_ready) state_d = mta_pkg::ST_MAC;
			mta_pkg::ST_MAC: begin
				if (!(is_dot || is_ew)) state_d = mta_pkg::ST_DONE;
				else if (last_k && last_ij)
					state_d = is_mm ? mta_pkg::ST_COPY : mta_pkg::ST_DONE;
			end
			mta_pkg::ST_COPY: if (i_q == LAST) state_d = mta_pkg::ST_DONE;
			mta_pkg::ST_DONE: state_d = mta_pkg::ST_IDLE;
			default: state_d = mta_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.i = i_q; cmd.j = j_q; cmd.k = k_q;
		cmd.load = state_q == mta_pkg::ST_IDLE && in_valid && in_ready;
		if (state_q == mta_pkg::ST_MAC && (is_dot || is_ew)) begin
			cmd.mac = 1'b1;
			cmd.clr_acc = k_q == '0;
			cmd.store = last_k;
		end
		cmd.copy = state_q == mta_pkg::ST_COPY;
		cmd.finish = state_q == mta_pkg::ST_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mta_pkg::ST_IDLE;
			i_q <= '0; j_q <= '0; k_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (state_q == mta_pkg::ST_MAC && cmd.mac) begin
				// advance k, then j, then i
				if (!last_k) k_q <= k_q + 2'd1;
				else begin
					k_q <= '0;
					if (j_q != LAST && sts.op != mta_pkg::OP_XFORM) j_q <= j_q + 2'd1;
					else begin
						j_q <= '0;
						i_q <= last_ij ? '0 : i_q + 2'd1;
					end
				end
			end else if (state_q == mta_pkg::ST_COPY)
				i_q <= i_q == LAST ? '0 : i_q + 2'd1;
		end
	end
endmodule

// ===== hdl/matrix_transform_accumulator_top.sv =====
// ---------------------------------------------------------------------------
// matrix_transform_accumulator_top
// Element write, element read and unknown ops go straight to the result;
// add, subtract, scale, transform and compose step the one shared MAC over
// their indices, and compose then copies its temp into current row by row.
// One item at a time: the next beat is taken at the earliest in the cycle
// out_valid rises if out_ready is high, not while a result waits unaccepted.
// Reset loads identity into current, zeros into operand.
// ---------------------------------------------------------------------------
module matrix_transform_accumulator_top #(
	parameter int DIM       = mta_pkg::DIM_DEF,
	parameter int FRAC_BITS = mta_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         op,
	input  logic [1:0]         row,
	input  logic [1:0]         col,
	input  logic signed [31:0] value,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [31:0] vec_w,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] res_0,
	output logic signed [31:0] res_1,
	output logic signed [31:0] res_2,
	output logic signed [31:0] res_3,
	output logic               saturated
);
	mta_pkg::cmd_t cmd;
	mta_pkg::sts_t sts;

	mta_ctrl #(.DIM(DIM)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
	);

	mta_datapath #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts, .op, .row, .col, .value,
		.vec_x, .vec_y, .vec_z, .vec_w,
		.res_0, .res_1, .res_2, .res_3, .saturated
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.mac) else $error("accept while busy");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_0))
		else $error("result dropped");
	a_finish_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !cmd.finish) else $error("double finish");
endmodule

// ===== tb/matrix_transform_accumulator_checker.sv =====
// ---------------------------------------------------------------------------
// matrix_transform_accumulator_checker
// Watches both channels of the matrix transform accumulator, tracks its two
// matrices, predicts every result beat and compares it field by field.
// ---------------------------------------------------------------------------
module matrix_transform_accumulator_checker #(
	parameter int DIM       = mta_pkg::DIM_DEF,
	parameter int FRAC_BITS = mta_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [3:0]         op,
	input  logic [1:0]         row,
	input  logic [1:0]         col,
	input  logic signed [31:0] value,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [31:0] vec_w,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] res_0,
	input  logic signed [31:0] res_1,
	input  logic signed [31:0] res_2,
	input  logic signed [31:0] res_3,
	input  logic               saturated,
	output int                 errors,
	output int                 pending,
	output int                 results_seen,
	output int                 clipped_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] r0;
		logic signed [31:0] r1;
		logic signed [31:0] r2;
		logic signed [31:0] r3;
		logic               sat;
	} answer_t;

	logic signed [31:0] cur_m [mta_pkg::CELLS];
	logic signed [31:0] opd_m [mta_pkg::CELLS];
	answer_t            answers [$];

	assign pending = answers.size();

	function automatic logic signed [63:0] fx_mul(logic signed [31:0] a,
			logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p >>> FRAC_BITS;
	endfunction

	function automatic logic signed [31:0] clip32(logic signed [63:0] x, ref logic flag);
		if (x > 64'sh7FFF_FFFF) begin
			flag = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (x < -64'sh8000_0000) begin
			flag = 1'b1;
			return 32'sh8000_0000;
		end
		return x[31:0];
	endfunction

	// compose into a temp, then copy back; swap picks operand * current
	function automatic void compose(bit swap, ref logic flag);
		logic signed [31:0] t [mta_pkg::CELLS];
		logic signed [63:0] acc;
		for (int n = 0; n < mta_pkg::CELLS; n++) t[n] = '0;
		for (int i = 0; i < DIM; i++)
			for (int j = 0; j < DIM; j++) begin
				acc = '0;
				for (int k = 0; k < DIM; k++)
					acc += swap
						? fx_mul(opd_m[i*mta_pkg::STRIDE+k], cur_m[k*mta_pkg::STRIDE+j])
						: fx_mul(cur_m[i*mta_pkg::STRIDE+k], opd_m[k*mta_pkg::STRIDE+j]);
				t[i*mta_pkg::STRIDE+j] = clip32(acc, flag);
			end
		for (int n = 0; n < mta_pkg::CELLS; n++) cur_m[n] = t[n];
	endfunction

	function automatic answer_t apply_op(logic [3:0] code, logic [1:0] r, logic [1:0] c,
			logic signed [31:0] v, logic signed [31:0] vx, logic signed [31:0] vy,
			logic signed [31:0] vz, logic signed [31:0] vw);
		answer_t            a;
		logic               flag;
		logic               in_range;
		int                 idx;
		logic signed [31:0] vec [4];
		logic signed [31:0] res [4];
		logic signed [63:0] acc;
		flag = 1'b0;
		in_range = (r < DIM) && (c < DIM);
		idx = r * mta_pkg::STRIDE + c;
		vec[0] = vx; vec[1] = vy; vec[2] = vz; vec[3] = vw;
		for (int n = 0; n < 4; n++) res[n] = '0;
		case (code)
			mta_pkg::OP_WR_CUR: if (in_range) cur_m[idx] = v;
			mta_pkg::OP_WR_OPD: if (in_range) opd_m[idx] = v;
			mta_pkg::OP_RD_CUR: if (in_range) res[0] = cur_m[idx];
			mta_pkg::OP_POSTMUL: compose(1'b0, flag);
			mta_pkg::OP_PREMUL: compose(1'b1, flag);
			mta_pkg::OP_ADD, mta_pkg::OP_SUB: begin
				for (int i = 0; i < DIM; i++)
					for (int j = 0; j < DIM; j++) begin
						idx = i * mta_pkg::STRIDE + j;
						acc = (code == mta_pkg::OP_ADD)
							? 64'(cur_m[idx]) + 64'(opd_m[idx])
							: 64'(cur_m[idx]) - 64'(opd_m[idx]);
						cur_m[idx] = clip32(acc, flag);
					end
			end
			mta_pkg::OP_SCALE: begin
				for (int i = 0; i < DIM; i++)
					for (int j = 0; j < DIM; j++) begin
						idx = i * mta_pkg::STRIDE + j;
						cur_m[idx] = clip32(fx_mul(cur_m[idx], v), flag);
					end
			end
			mta_pkg::OP_XFORM: begin
				for (int i = 0; i < DIM; i++) begin
					acc = '0;
					for (int j = 0; j < DIM; j++)
						acc += fx_mul(cur_m[i*mta_pkg::STRIDE+j], vec[j]);
					res[i] = clip32(acc, flag);
				end
			end
			default: ;
		endcase
		a.r0 = res[0]; a.r1 = res[1]; a.r2 = res[2]; a.r3 = res[3];
		a.sat = flag;
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t exp_a;
		answer_t got;
		if (!arst_n) begin
			for (int n = 0; n < mta_pkg::CELLS; n++) begin
				cur_m[n] = '0;
				opd_m[n] = '0;
			end
			for (int i = 0; i < DIM; i++)
				cur_m[i*mta_pkg::STRIDE+i] = 32'sd1 <<< FRAC_BITS;
			answers.delete();
			errors = 0;
			results_seen = 0;
			clipped_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{res_0, res_1, res_2, res_3, saturated};
				results_seen++;
				if (saturated) clipped_seen++;
				if (answers.size() == 0) begin
					errors++;
					if (errors <= 10) $display("%0t: unexpected result beat", $realtime);
				end else begin
					exp_a = answers.pop_front();
					if (got !== exp_a) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: mismatch exp %0d %0d %0d %0d sat %0b",
								" got %0d %0d %0d %0d sat %0b"},
								$realtime, exp_a.r0, exp_a.r1, exp_a.r2, exp_a.r3, exp_a.sat,
								got.r0, got.r1, got.r2, got.r3, got.sat);
					end
				end
			end
			if (in_valid && in_ready)
				answers.push_back(apply_op(op, row, col, value, vec_x, vec_y, vec_z, vec_w));
		end
	end

endmodule

// ===== tb/matrix_transform_accumulator_top_tb.sv =====
// ---------------------------------------------------------------------------
// matrix_transform_accumulator_top_tb
// Directed and random operation sequences with random gaps on both channels
// and one long output stall; results are checked by a separate checker.
// ---------------------------------------------------------------------------
module matrix_transform_accumulator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         op;
	logic [1:0]         row;
	logic [1:0]         col;
	logic signed [31:0] value;
	logic signed [31:0] vec_x, vec_y, vec_z, vec_w;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] res_0, res_1, res_2, res_3;
	logic               saturated;
	int                 errors, pending, results_seen, clipped_seen;
	int                 idle_cycles = 0;
	bit                 hold_off;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	matrix_transform_accumulator_top u_dut (.*);

	matrix_transform_accumulator_checker u_chk (.*);

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// mostly small Q16.16 values, sometimes the extremes or raw bits
	function automatic logic signed [31:0] pick_val();
		int p;
		p = $urandom_range(0, 9);
		case (p)
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return $urandom();
			default: return $signed(32'($urandom_range(0, 32'h0006_0000))) - 32'sh0003_0000;
		endcase
	endfunction

	// keep valid high straight into the next beat when there is no gap
	task automatic send(logic [3:0] o, logic [1:0] r, logic [1:0] c, logic signed [31:0] v,
			logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
			logic signed [31:0] w);
		int g;
		in_valid <= 1'b1;
		op <= o; row <= r; col <= c; value <= v;
		vec_x <= x; vec_y <= y; vec_z <= z; vec_w <= w;
		do @(posedge clk); while (!in_ready);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_rand();
		int p;
		logic [3:0] o;
		p = $urandom_range(0, 99);
		if (p < 30) o = mta_pkg::OP_WR_OPD;
		else if (p < 45) o = mta_pkg::OP_WR_CUR;
		else if (p < 57) o = mta_pkg::OP_RD_CUR;
		else if (p < 75) o = mta_pkg::OP_XFORM;
		else if (p < 97) o = 4'($urandom_range(mta_pkg::OP_POSTMUL, mta_pkg::OP_SCALE));
		else o = 4'($urandom_range(9, 15));
		send(o, 2'($urandom()), 2'($urandom()), pick_val(), pick_val(), pick_val(),
			pick_val(), pick_val());
	endtask

	// sink side: random stalls, plus one long hold-off on request
	initial begin
		int g;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			g = gap_len();
			if (g == 0 || $urandom_range(0, 3) == 0) out_ready <= 1'b1;
			else begin
				out_ready <= 1'b0;
				repeat (g - 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		hold_off = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = '0; row = '0; col = '0; value = '0;
		vec_x = '0; vec_y = '0; vec_z = '0; vec_w = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity read and transform, extremes, every op
		send(mta_pkg::OP_RD_CUR, 2'd3, 2'd3, '0, '0, '0, '0, '0);
		send(mta_pkg::OP_XFORM, 2'd0, 2'd0, '0, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh0001_0000, -32'sd1);
		send(mta_pkg::OP_WR_CUR, 2'd0, 2'd1, 32'sh7FFF_FFFF, '0, '0, '0, '0);
		send(mta_pkg::OP_XFORM, 2'd0, 2'd0, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, '0);
		send(mta_pkg::OP_WR_OPD, 2'd0, 2'd0, 32'sh8000_0000, '0, '0, '0, '0);
		send(mta_pkg::OP_WR_OPD, 2'd3, 2'd2, 32'sh0002_8000, '0, '0, '0, '0);
		send(mta_pkg::OP_WR_OPD, 2'd1, 2'd1, -32'sh0000_8000, '0, '0, '0, '0);
		send(mta_pkg::OP_POSTMUL, 2'd0, 2'd0, '0, '0, '0, '0, '0);
		send(mta_pkg::OP_PREMUL, 2'd0, 2'd0, '0, '0, '0, '0, '0);
		send(mta_pkg::OP_ADD, 2'd0, 2'd0, '0, '0, '0, '0, '0);
		send(mta_pkg::OP_SUB, 2'd0, 2'd0, '0, '0, '0, '0, '0);
		send(mta_pkg::OP_SUB, 2'd0, 2'd0, '0, '0, '0, '0, '0);
		send(mta_pkg::OP_SCALE, 2'd0, 2'd0, 32'sh8000_0000, '0, '0, '0, '0);
		send(mta_pkg::OP_SCALE, 2'd0, 2'd0, -32'sd1, '0, '0, '0, '0);
		send(mta_pkg::OP_SCALE, 2'd0, 2'd0, 32'sh7FFF_FFFF, '0, '0, '0, '0);
		send(4'd9, 2'd2, 2'd1, 32'sh1234_5678, '0, '0, '0, '0);
		send(4'd15, 2'd3, 2'd3, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
		for (int i = 0; i < 4; i++)
			send(mta_pkg::OP_RD_CUR, 2'(i), 2'(3 - i), '0, '0, '0, '0, '0);
		send(mta_pkg::OP_XFORM, 2'd0, 2'd0, '0, -32'sd1, -32'sd1, -32'sd1, -32'sd1);

		// random, with one long output stall partway through
		for (int n = 0; n < 1000; n++) begin
			if (n == 300) hold_off = 1'b1;
			send_rand();
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered every op code, index edges and clipping: %0d results checked, %0d clipped.",
			results_seen, clipped_seen);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== matrix_transform_accumulator_top.f =====
hdl/mta_pkg.sv
hdl/mta_datapath.sv
hdl/mta_ctrl.sv
hdl/matrix_transform_accumulator_top.sv
tb/matrix_transform_accumulator_checker.sv
tb/matrix_transform_accumulator_top_tb.sv
